/* rtl/core/dltsd_pkg.sv */
package dltsd_pkg;

    // Serial magic "DLS" 0x01
    localparam logic [31:0] MAGIC_WORD = 32'h444C_5301;

    // Header type flag bit positions
    localparam int FLAG_UEH  = 0;
    localparam int FLAG_MSBF = 1;
    localparam int FLAG_WEID = 2;
    localparam int FLAG_WSID = 3;
    localparam int FLAG_WTMS = 4;

    // Result kinds
    localparam logic [3:0] KIND_HEADER  = 4'd0;
    localparam logic [3:0] KIND_ECU     = 4'd1;
    localparam logic [3:0] KIND_SESSION = 4'd2;
    localparam logic [3:0] KIND_TMS     = 4'd3;
    localparam logic [3:0] KIND_EXT     = 4'd4;
    localparam logic [3:0] KIND_APP     = 4'd5;
    localparam logic [3:0] KIND_CTX     = 4'd6;
    localparam logic [3:0] KIND_MSGID   = 4'd7;
    localparam logic [3:0] KIND_PAYLOAD = 4'd8;
    localparam logic [3:0] KIND_ERROR   = 4'd9;

    // Error codes
    localparam logic [31:0] ERR_SIZE_RANGE = 32'd1;
    localparam logic [31:0] ERR_SIZE_SHORT = 32'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_TOTAL = 1'b0;
    localparam logic CFG_MAX_TOTAL = 1'b1;

    // Order of the parse phases within a packet
    localparam logic [3:0] RANK_HDR   = 4'd1;
    localparam logic [3:0] RANK_ECU   = 4'd2;
    localparam logic [3:0] RANK_SESS  = 4'd3;
    localparam logic [3:0] RANK_TMS   = 4'd4;
    localparam logic [3:0] RANK_EXT   = 4'd5;
    localparam logic [3:0] RANK_CTX   = 4'd7;
    localparam logic [3:0] RANK_MSGID = 4'd8;

    // Parse phases, one-hot
    typedef enum logic [10:0] {
        PH_HUNT    = 11'b000_0000_0001,
        PH_HDR     = 11'b000_0000_0010,
        PH_ECU     = 11'b000_0000_0100,
        PH_SESS    = 11'b000_0000_1000,
        PH_TMS     = 11'b000_0001_0000,
        PH_EXT     = 11'b000_0010_0000,
        PH_APP     = 11'b000_0100_0000,
        PH_CTX     = 11'b000_1000_0000,
        PH_MSGID   = 11'b001_0000_0000,
        PH_PAYLOAD = 11'b010_0000_0000,
        PH_SKIP    = 11'b100_0000_0000
    } t_phase;

endpackage

/* rtl/core/dlt_serial_stream_deframer.sv */
// Serial log stream deframer. One stream byte is taken per request on the input
// channel, and a new byte can be taken in every clock cycle: each byte updates
// the parse state, and the result it completes (if any) is registered into the
// output queue when the byte is accepted. Results go through
// a two-entry output queue, so input keeps flowing while a result waits; the
// input stalls only while both queue entries are occupied. The block hunts for
// the magic 44 4C 53 01, checks the packet size against min/max_total_size
// (configuration index 0 and 1), then emits header fields, ids, extended info,
// message id and payload bytes, with o_last on the final result of a packet
// and on every error.
module dlt_serial_stream_deframer
    import dltsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // input bytes
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [31:0] o_value,
    output logic        o_last
);

    // Configuration registers
    logic [16:0] r_min_total;
    logic [16:0] r_max_total;

    // Parse state
    t_phase      r_phase,   n_phase;
    logic [31:0] r_window,  n_window;
    logic [7:0]  r_flags,   n_flags;
    logic [16:0] r_left,    n_left;
    logic [31:0] r_acc,     n_acc;
    logic [1:0]  r_idx,     n_idx;
    logic        r_verbose, n_verbose;

    // Result produced by the current byte
    logic        e_valid;
    logic [3:0]  e_kind;
    logic [31:0] e_value;
    logic        e_last;

    // Output queue
    logic [3:0]  r_q_kind  [2];
    logic [31:0] r_q_value [2];
    logic        r_q_last  [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic        in_take;
    logic        push;
    logic        pop;

    // Next phase after a field completes
    function automatic t_phase pick_next(input logic [3:0]  from_rank,
                                         input logic [16:0] left,
                                         input logic [7:0]  flags,
                                         input logic        verbose);
        t_phase ph;
        if (left == 17'd0)                                   ph = PH_HUNT;
        else if (from_rank < RANK_ECU  && flags[FLAG_WEID])  ph = PH_ECU;
        else if (from_rank < RANK_SESS && flags[FLAG_WSID])  ph = PH_SESS;
        else if (from_rank < RANK_TMS  && flags[FLAG_WTMS])  ph = PH_TMS;
        else if (from_rank < RANK_EXT  && flags[FLAG_UEH])   ph = PH_EXT;
        else if (from_rank < RANK_MSGID && !verbose && left >= 17'd4) ph = PH_MSGID;
        else                                                 ph = PH_PAYLOAD;
        return ph;
    endfunction

    // Handshakes
    assign o_in_stall  = (r_count == 2'd2);
    assign in_take     = i_in_valid && !o_in_stall;
    assign push        = in_take && e_valid;
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && !i_out_stall;

    assign o_kind  = r_q_kind[r_rd_ptr];
    assign o_value = r_q_value[r_rd_ptr];
    assign o_last  = r_q_last[r_rd_ptr];

    // Per-byte parse step
    always_comb begin
        logic [31:0] win_sh;
        logic [31:0] acc_sh;
        logic [31:0] acc_4b;
        logic [16:0] total;
        logic [16:0] need;
        logic [16:0] left_dec;
        logic [16:0] left_new;
        logic [3:0]  rank;
        logic [3:0]  kind4;
        logic        big;

        win_sh   = {r_window[23:0], i_data_byte};
        acc_sh   = {r_acc[23:0], i_data_byte};
        total    = {1'b0, acc_sh[15:0]} + 17'd4;
        need     = 17'd8
                 + (r_flags[FLAG_WEID] ? 17'd4  : 17'd0)
                 + (r_flags[FLAG_WSID] ? 17'd4  : 17'd0)
                 + (r_flags[FLAG_WTMS] ? 17'd4  : 17'd0)
                 + (r_flags[FLAG_UEH]  ? 17'd10 : 17'd0);
        left_dec = r_left - 17'd1;
        left_new = 17'd0;
        big      = 1'b0;
        acc_4b   = 32'd0;
        rank     = RANK_ECU;
        kind4    = KIND_ECU;

        n_phase   = r_phase;
        n_window  = win_sh;
        n_flags   = r_flags;
        n_left    = r_left;
        n_acc     = r_acc;
        n_idx     = r_idx;
        n_verbose = r_verbose;

        e_valid = 1'b0;
        e_kind  = KIND_HEADER;
        e_value = 32'd0;
        e_last  = 1'b0;

        unique case (r_phase)
            PH_HUNT: begin
                if (win_sh == MAGIC_WORD) begin
                    n_phase = PH_HDR;
                    n_acc   = 32'd0;
                    n_idx   = 2'd0;
                end
            end

            PH_HDR: begin
                if (r_idx == 2'd0) n_flags = i_data_byte;
                if (r_idx != 2'd3) begin
                    n_acc = acc_sh;
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_acc   = 32'd0;
                    n_idx   = 2'd0;
                    e_valid = 1'b1;
                    e_kind  = KIND_ERROR;
                    e_last  = 1'b1;
                    if (total < r_min_total || total > r_max_total) begin
                        // recheck the header bytes for a magic at once
                        e_value  = ERR_SIZE_RANGE;
                        n_window = acc_sh;
                        n_phase  = (acc_sh == MAGIC_WORD) ? PH_HDR : PH_HUNT;
                    end else if (total < need) begin
                        // too short for its optional fields: skip the rest
                        e_value   = ERR_SIZE_SHORT;
                        n_verbose = 1'b0;
                        left_new  = (total > 17'd8) ? total - 17'd8 : 17'd0;
                        n_left    = left_new;
                        if (left_new != 17'd0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase  = PH_HUNT;
                            n_window = 32'd0;
                        end
                    end else begin
                        n_verbose = 1'b0;
                        left_new  = total - 17'd8;
                        n_left    = left_new;
                        n_phase   = pick_next(RANK_HDR, left_new, r_flags, 1'b0);
                        if (left_new == 17'd0) n_window = 32'd0;
                        e_kind    = KIND_HEADER;
                        e_value   = acc_sh;
                        e_last    = (left_new == 17'd0);
                    end
                end
            end

            PH_SKIP: begin
                n_left = left_dec;
                if (left_dec == 17'd0) begin
                    n_phase  = PH_HUNT;
                    n_window = 32'd0;
                    n_acc    = 32'd0;
                    n_idx    = 2'd0;
                end
            end

            PH_PAYLOAD: begin
                n_left  = left_dec;
                e_valid = 1'b1;
                e_kind  = KIND_PAYLOAD;
                e_value = {24'd0, i_data_byte};
                e_last  = (left_dec == 17'd0);
                if (left_dec == 17'd0) begin
                    n_phase  = PH_HUNT;
                    n_window = 32'd0;
                    n_acc    = 32'd0;
                    n_idx    = 2'd0;
                end
            end

            PH_EXT: begin
                n_left = left_dec;
                if (r_idx == 2'd0) begin
                    // message info byte, held until the argument count arrives
                    n_acc = {24'd0, i_data_byte};
                    n_idx = 2'd1;
                end else begin
                    n_verbose = r_acc[0];
                    e_valid   = 1'b1;
                    e_kind    = KIND_EXT;
                    e_value   = {16'd0, i_data_byte, r_acc[7:0]};
                    e_last    = (left_dec == 17'd0);
                    n_acc     = 32'd0;
                    n_idx     = 2'd0;
                    if (left_dec != 17'd0) begin
                        n_phase = PH_APP;
                    end else begin
                        n_phase  = PH_HUNT;
                        n_window = 32'd0;
                    end
                end
            end

            PH_ECU, PH_SESS, PH_TMS, PH_APP, PH_CTX, PH_MSGID: begin
                n_left = left_dec;
                unique case (r_phase)
                    PH_ECU:  begin rank = RANK_ECU;   kind4 = KIND_ECU;     end
                    PH_SESS: begin rank = RANK_SESS;  kind4 = KIND_SESSION; end
                    PH_TMS:  begin rank = RANK_TMS;   kind4 = KIND_TMS;     end
                    PH_APP:  begin rank = RANK_CTX;   kind4 = KIND_APP;     end
                    PH_CTX:  begin rank = RANK_CTX;   kind4 = KIND_CTX;     end
                    default: begin rank = RANK_MSGID; kind4 = KIND_MSGID;   end
                endcase
                // ids are always first byte high, others follow MSBF
                big = (r_phase == PH_ECU) || (r_phase == PH_APP) ||
                      (r_phase == PH_CTX) || r_flags[FLAG_MSBF];
                if (big) begin
                    acc_4b = acc_sh;
                end else begin
                    acc_4b = r_acc | ({24'd0, i_data_byte} << {r_idx, 3'b000});
                end
                if (r_idx != 2'd3) begin
                    n_acc = acc_4b;
                    n_idx = r_idx + 2'd1;
                end else begin
                    e_valid = 1'b1;
                    e_kind  = kind4;
                    e_value = acc_4b;
                    e_last  = (left_dec == 17'd0);
                    n_acc   = 32'd0;
                    n_idx   = 2'd0;
                    if (r_phase == PH_APP) begin
                        n_phase = (left_dec != 17'd0) ? PH_CTX : PH_HUNT;
                    end else begin
                        n_phase = pick_next(rank, left_dec, r_flags, r_verbose);
                    end
                    if (left_dec == 17'd0) n_window = 32'd0;
                end
            end

            default: begin
                n_phase  = PH_HUNT;
                n_window = 32'd0;
                n_acc    = 32'd0;
                n_idx    = 2'd0;
            end
        endcase
    end

    // Configuration and parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_total <= 17'd8;
            r_max_total <= 17'd65539;
            r_phase     <= PH_HUNT;
            r_window    <= 32'd0;
            r_flags     <= 8'd0;
            r_left      <= 17'd0;
            r_acc       <= 32'd0;
            r_idx       <= 2'd0;
            r_verbose   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN_TOTAL: r_min_total <= i_cfg_data;
                    CFG_MAX_TOTAL: r_max_total <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_phase   <= n_phase;
                r_window  <= n_window;
                r_flags   <= n_flags;
                r_left    <= n_left;
                r_acc     <= n_acc;
                r_idx     <= n_idx;
                r_verbose <= n_verbose;
            end
        end
    end

    // Output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Output queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_kind[r_wr_ptr]  <= e_kind;
            r_q_value[r_wr_ptr] <= e_value;
            r_q_last[r_wr_ptr]  <= e_last;
        end
    end

    // Assertions
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ERROR) |-> o_last)
        else $error("error result without last");

    a_error_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && e_kind == KIND_ERROR) |=>
            (r_phase == PH_HUNT || r_phase == PH_HDR || r_phase == PH_SKIP))
        else $error("parser not hunting or skipping after an error");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_SKIP) |-> (r_left != 17'd0))
        else $error("payload or skip phase with no bytes left");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_idx == 2'd0 && r_acc == 32'd0))
        else $error("field state not cleared while hunting");

endmodule

/* tb/sv/dlt_serial_stream_deframer_test.sv */
`timescale 1ns / 1ps

module dlt_serial_stream_deframer_test;
    import dltsd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic        last;
    } t_dlt_field;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_dlt_field want;
    } t_stim_row;

    localparam t_dlt_field NO_FIELD = '0;

    // DUT signals; the driven inputs are known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_MIN_TOTAL;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [31:0] value;
    logic        last;

    // Expected fields, oldest first
    t_dlt_field expected_fields[$];
    bit         failed = 1'b0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         fields_taken = 0;
    int         send_gap_max = 0;

    // Deframer state mirror
    logic [31:0] stream_window;
    t_phase      cur_section;
    logic [7:0]  htyp_flags;
    logic [16:0] bytes_to_go;
    logic [31:0] field_acc;
    logic [3:0]  field_idx;
    logic        verbose_mode;
    logic [16:0] min_total;
    logic [16:0] max_total;

    // Directed stream: size range error, too-short error, minimal good packet
    t_stim_row directed_rows [N_DIRECTED] = '{
        {8'h44, 1'b0, NO_FIELD}, {8'h4C, 1'b0, NO_FIELD},
        {8'h53, 1'b0, NO_FIELD}, {8'h01, 1'b0, NO_FIELD},
        {8'h00, 1'b0, NO_FIELD}, {8'h00, 1'b0, NO_FIELD},
        {8'h00, 1'b0, NO_FIELD},
        {8'h00, 1'b1, KIND_ERROR, ERR_SIZE_RANGE, 1'b1},
        {8'h44, 1'b0, NO_FIELD}, {8'h4C, 1'b0, NO_FIELD},
        {8'h53, 1'b0, NO_FIELD}, {8'h01, 1'b0, NO_FIELD},
        {8'h04, 1'b0, NO_FIELD}, {8'h00, 1'b0, NO_FIELD},
        {8'h00, 1'b0, NO_FIELD},
        {8'h04, 1'b1, KIND_ERROR, ERR_SIZE_SHORT, 1'b1},
        {8'h44, 1'b0, NO_FIELD}, {8'h4C, 1'b0, NO_FIELD},
        {8'h53, 1'b0, NO_FIELD}, {8'h01, 1'b0, NO_FIELD},
        {8'h00, 1'b0, NO_FIELD}, {8'hFF, 1'b0, NO_FIELD},
        {8'h00, 1'b0, NO_FIELD},
        {8'h05, 1'b1, KIND_HEADER, 32'h00FF_0005, 1'b0},
        {8'hFF, 1'b1, KIND_PAYLOAD, 32'h0000_00FF, 1'b1}
    };

    dlt_serial_stream_deframer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_kind      (kind),
        .o_value     (value),
        .o_last      (last)
    );

    always #1 clk = ~clk;

    function automatic t_dlt_field make_field(input logic [3:0] k, input logic [31:0] v,
                                              input logic l);
        t_dlt_field f;
        f.kind = k;
        f.value = v;
        f.last = l;
        return f;
    endfunction

    function automatic void enter_section(input t_phase p);
        cur_section = p;
        field_acc = '0;
        field_idx = '0;
        if (p == PH_HUNT)
            stream_window = '0;
    endfunction

    // Next section of the packet after 'from', given the header flags
    function automatic t_phase next_section(input t_phase from);
        if (bytes_to_go == 0) return PH_HUNT;
        if (from < PH_ECU && htyp_flags[FLAG_WEID]) return PH_ECU;
        if (from < PH_SESS && htyp_flags[FLAG_WSID]) return PH_SESS;
        if (from < PH_TMS && htyp_flags[FLAG_WTMS]) return PH_TMS;
        if (from < PH_EXT && htyp_flags[FLAG_UEH]) return PH_EXT;
        if (from < PH_MSGID && !verbose_mode && bytes_to_go >= 4) return PH_MSGID;
        return PH_PAYLOAD;
    endfunction

    // Advance the deframer by one byte; returns 1 when a field completes
    function automatic bit deframe_byte(input logic [7:0] b, output t_dlt_field f);
        t_phase      ph;
        logic [16:0] total;
        logic [16:0] need;
        logic [31:0] val;
        logic [3:0]  k;
        ph = cur_section;
        f = NO_FIELD;
        stream_window = {stream_window[23:0], b};

        if (ph == PH_HUNT) begin
            if (stream_window == MAGIC_WORD)
                enter_section(PH_HDR);
            return 1'b0;
        end

        // standard header: htyp, counter, length (big-endian)
        if (ph == PH_HDR) begin
            if (field_idx == 0)
                htyp_flags = b;
            field_acc = {field_acc[23:0], b};
            field_idx++;
            if (field_idx < 4)
                return 1'b0;
            val = field_acc;
            total = 17'd4 + {1'b0, val[15:0]};
            if (total < min_total || total > max_total) begin
                enter_section(PH_HUNT);
                stream_window = val;
                if (stream_window == MAGIC_WORD)
                    enter_section(PH_HDR);
                f = make_field(KIND_ERROR, ERR_SIZE_RANGE, 1'b1);
                return 1'b1;
            end
            need = 17'd8;
            if (htyp_flags[FLAG_WEID]) need += 17'd4;
            if (htyp_flags[FLAG_WSID]) need += 17'd4;
            if (htyp_flags[FLAG_WTMS]) need += 17'd4;
            if (htyp_flags[FLAG_UEH])  need += 17'd10;
            verbose_mode = 1'b0;
            if (total < need) begin
                bytes_to_go = (total > 17'd8) ? total - 17'd8 : '0;
                enter_section((bytes_to_go != 0) ? PH_SKIP : PH_HUNT);
                f = make_field(KIND_ERROR, ERR_SIZE_SHORT, 1'b1);
                return 1'b1;
            end
            bytes_to_go = total - 17'd8;
            enter_section(next_section(PH_HDR));
            f = make_field(KIND_HEADER, val, bytes_to_go == 0);
            return 1'b1;
        end

        bytes_to_go = bytes_to_go - 17'd1;

        if (ph == PH_SKIP) begin
            if (bytes_to_go == 0)
                enter_section(PH_HUNT);
            return 1'b0;
        end

        if (ph == PH_PAYLOAD) begin
            if (bytes_to_go == 0)
                enter_section(PH_HUNT);
            f = make_field(KIND_PAYLOAD, {24'b0, b}, bytes_to_go == 0);
            return 1'b1;
        end

        // extended header: message info byte, then argument count
        if (ph == PH_EXT) begin
            if (field_idx == 0) begin
                field_acc = {24'b0, b};
                field_idx = 4'd1;
                return 1'b0;
            end
            verbose_mode = field_acc[0];
            val = {16'b0, b, field_acc[7:0]};
            enter_section((bytes_to_go != 0) ? PH_APP : PH_HUNT);
            f = make_field(KIND_EXT, val, bytes_to_go == 0);
            return 1'b1;
        end

        // four-byte fields; ids always first byte high, others per MSBF
        if (ph == PH_ECU || ph == PH_APP || ph == PH_CTX || htyp_flags[FLAG_MSBF])
            field_acc = {field_acc[23:0], b};
        else
            field_acc = field_acc | ({24'b0, b} << (8 * field_idx[1:0]));
        field_idx++;
        if (field_idx < 4)
            return 1'b0;
        val = field_acc;
        case (ph)
            PH_ECU:  k = KIND_ECU;
            PH_SESS: k = KIND_SESSION;
            PH_TMS:  k = KIND_TMS;
            PH_APP:  k = KIND_APP;
            PH_CTX:  k = KIND_CTX;
            default: k = KIND_MSGID;
        endcase
        if (ph == PH_APP)
            enter_section((bytes_to_go != 0) ? PH_CTX : PH_HUNT);
        else
            enter_section(next_section(ph));
        f = make_field(k, val, bytes_to_go == 0);
        return 1'b1;
    endfunction

    // Offer one byte after a random gap, wait for acceptance, predict its field
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input t_dlt_field want = '0);
        int gap;
        t_dlt_field got;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        if (deframe_byte(b, got) && !typed)
            expected_fields.push_back(got);
        if (typed)
            expected_fields.push_back(want);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_magic();
        send_byte(MAGIC_WORD[31:24]);
        send_byte(MAGIC_WORD[23:16]);
        send_byte(MAGIC_WORD[15:8]);
        send_byte(MAGIC_WORD[7:0]);
    endtask

    // Wait until every expected field is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_fields.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_TOTAL)
            min_total = val;
        else
            max_total = val;
        @(negedge clk);
    endtask

    // One packet, mostly well formed, sometimes noise or a broken frame
    task automatic send_packet();
        int choice;
        int sel;
        int need;
        int total;
        int n_body;
        logic [7:0]  htyp;
        logic [15:0] len16;
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        choice = $urandom_range(0, 99);
        if (choice < 10) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        // magic where the header belongs: range error, then recheck of the window
        if (choice < 14 && max_total < 17'd21253) begin
            send_magic();
            send_magic();
            return;
        end
        if (choice < 18) begin
            send_byte(MAGIC_WORD[31:24]);
            send_byte(MAGIC_WORD[23:16]);
            send_byte(MAGIC_WORD[15:8]);
        end
        htyp = 8'($urandom_range(0, 255));
        need = 8 + (htyp[FLAG_WEID] ? 4 : 0) + (htyp[FLAG_WSID] ? 4 : 0) +
               (htyp[FLAG_WTMS] ? 4 : 0) + (htyp[FLAG_UEH] ? 10 : 0);
        sel = $urandom_range(0, 99);
        if (sel < 8)
            total = $urandom_range(4, need - 1);
        else if (sel < 14 && max_total < 17'd1000)
            total = 4 + $urandom_range(0, 65535);
        else
            total = need + $urandom_range(0, 12);
        len16 = 16'(total - 4);
        send_magic();
        send_byte(htyp);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len16[15:8]);
        send_byte(len16[7:0]);
        if (total < min_total || total > max_total || total <= 8)
            return;
        n_body = total - 8;
        if ($urandom_range(0, 19) == 0)
            n_body = $urandom_range(0, n_body);
        repeat (n_body) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input logic [16:0] lo, input logic [16:0] hi, input int n_items);
        int stop_at;
        drain();
        write_cfg(CFG_MIN_TOTAL, lo);
        write_cfg(CFG_MAX_TOTAL, hi);
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at)
            send_packet();
    endtask

    // Result checker: compare each accepted field with the oldest expectation
    always @(posedge clk) begin
        t_dlt_field want;
        if (rst_n && out_valid && !out_stall) begin
            fields_taken++;
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected field: kind=%0d value=%h last=%b",
                         $time, kind, value, last);
                failed = 1'b1;
            end else begin
                want = expected_fields.pop_front();
                if (kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                    failed = 1'b1;
                end
                if (value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, value);
                    failed = 1'b1;
                end
                if (last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver back-pressure: after each taken field, stall a random while
    initial begin : receiver
        int hold;
        int seen;
        int mode_left;
        int stall_max;
        hold = 0;
        seen = 0;
        mode_left = 0;
        stall_max = 0;
        forever begin
            @(negedge clk);
            if (seen != fields_taken) begin
                seen = fields_taken;
                if (mode_left == 0) begin
                    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
                    mode_left = 16;
                end
                mode_left--;
                hold = $urandom_range(0, stall_max);
            end
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("dlt_serial_stream_deframer verification failed");
            $finish;
        end
    end

    initial begin
        stream_window = '0;
        cur_section = PH_HUNT;
        htyp_flags = '0;
        bytes_to_go = '0;
        field_acc = '0;
        field_idx = '0;
        verbose_mode = 1'b0;
        min_total = 17'd8;
        max_total = 17'd65539;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stream at reset configuration
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        // random streams over several size windows, extremes included
        run_phase(17'd8, 17'd65539, 100);
        run_phase(17'd8, 17'd8, 100);
        run_phase(17'd20, 17'd64, 100);
        run_phase(17'd65539, 17'd65539, 100);
        run_phase(17'd40, 17'd12, 100);
        run_phase(17'd12, 17'd100, 100);
        run_phase(17'd8, 17'd65539, 100);

        drain();
        repeat (20) @(negedge clk);
        if (!failed && expected_fields.size() == 0)
            $display("dlt_serial_stream_deframer verification clean");
        else
            $display("dlt_serial_stream_deframer verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/dltsd_pkg.sv
rtl/core/dlt_serial_stream_deframer.sv
tb/sv/dlt_serial_stream_deframer_test.sv
